FILE: hw/rtl/lbhr_pkg.sv
// Shared types, constants and helpers of the load-balancer header rewrite unit.
package lbhr_pkg;

    localparam int HDR_LEN   = 34;
    localparam int POS_W     = 6;
    localparam int RAM_DEPTH = 2 * HDR_LEN;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int OQ_DEPTH  = 4;
    localparam int OQ_CW     = $clog2(OQ_DEPTH + 1);
    localparam int SUM_W     = 20;

    // Header byte offsets
    localparam logic [POS_W-1:0] POS_ETYPE_HI = 6'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd13;
    localparam logic [POS_W-1:0] POS_IP_START = 6'd14;
    localparam logic [POS_W-1:0] POS_PROTO    = 6'd23;
    localparam logic [POS_W-1:0] POS_CK_HI    = 6'd24;
    localparam logic [POS_W-1:0] POS_CK_LO    = 6'd25;
    localparam logic [POS_W-1:0] POS_DIP_0    = 6'd30;
    localparam logic [POS_W-1:0] POS_DIP_1    = 6'd31;
    localparam logic [POS_W-1:0] POS_DIP_2    = 6'd32;
    localparam logic [POS_W-1:0] POS_DIP_3    = 6'd33;
    localparam logic [POS_W-1:0] POS_LAST     = 6'd33;
    localparam logic [POS_W-1:0] POS_BODY     = 6'd34;

    localparam logic [7:0] ETYPE_HI  = 8'h08;
    localparam logic [7:0] ETYPE_LO  = 8'h00;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Configuration register indexes
    localparam logic [1:0] CFG_BACKEND0_IP  = 2'd0;
    localparam logic [1:0] CFG_BACKEND0_MAC = 2'd1;
    localparam logic [1:0] CFG_BACKEND1_IP  = 2'd2;
    localparam logic [1:0] CFG_BACKEND1_MAC = 2'd3;

    // Command from front to back: one body byte or one buffered header
    typedef struct packed {
        logic             is_hdr;
        logic             bank;
        logic [POS_W-1:0] len;
        logic             last;
        logic             verdict;
        logic [7:0]       data;
        logic [47:0]      mac;
        logic [31:0]      ip;
        logic [15:0]      cksum;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       verdict;
    } obeat_t;

    // Header bank handed back by the back end
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    function automatic logic [RAM_AW-1:0] bank_addr(input logic bank,
                                                   input logic [POS_W-1:0] pos);
        logic [RAM_AW-1:0] base;
        base = bank ? RAM_AW'(HDR_LEN) : '0;
        return base + RAM_AW'(pos);
    endfunction

endpackage

FILE: hw/rtl/lbhr_ram.sv
// Generic simple dual-port RAM with registered read.
module lbhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 68
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/lbhr_fifo.sv
// Small register FIFO used for the command queue and the result queue.
module lbhr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

FILE: hw/rtl/lbhr_front.sv
// Front end: accepts frame bytes, buffers headers, classifies and queues commands.
module lbhr_front
    import lbhr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [47:0]       cfg_data,
    input  logic              cmdq_full,
    output logic              cmd_push,
    output cmd_t              cmd,
    output logic              ram_we,
    output logic [RAM_AW-1:0] ram_waddr,
    output logic [7:0]        ram_wdata,
    input  release_t          rel
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             wbank_reg, wbank_next;
    logic [1:0]       busy_reg, busy_next;
    logic             next_be_reg, next_be_next;
    logic             verdict_reg, verdict_next;
    logic [7:0]       etype_hi_reg, etype_lo_reg, proto_reg, hi_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [31:0]      b0_ip_reg, b1_ip_reg;
    logic [47:0]      b0_mac_reg, b1_mac_reg;

    logic        acc, in_hdr, full_hdr, hdr_end, fwd, ck_word;
    logic [47:0] sel_mac;
    logic [31:0] sel_ip;
    logic [16:0] fold1;
    logic [16:0] fold2;

    assign cfg_ready = 1'b1;
    assign in_hdr    = (pos_reg != POS_BODY);
    assign full      = cmdq_full || (in_hdr && busy_reg[wbank_reg]);
    assign acc       = push && !full;
    assign full_hdr  = (pos_reg == POS_LAST);
    assign hdr_end   = acc && in_hdr && (full_hdr || in_last);

    assign sel_mac = next_be_reg ? b1_mac_reg : b0_mac_reg;
    assign sel_ip  = next_be_reg ? b1_ip_reg : b0_ip_reg;
    assign fwd     = (etype_hi_reg == ETYPE_HI) && (etype_lo_reg == ETYPE_LO) &&
                     ((proto_reg == PROTO_TCP) || (proto_reg == PROTO_UDP));

    // Odd byte of an IP header word that enters the checksum (check field skipped)
    assign ck_word = pos_reg[0] && (pos_reg > POS_IP_START) && (pos_reg < POS_DIP_0) &&
                     (pos_reg != POS_CK_LO);

    // Fold twice, then invert
    assign fold1 = {1'b0, sum_reg[15:0]} + 17'(sum_reg[SUM_W-1:16]);
    assign fold2 = {1'b0, fold1[15:0]} + 17'(fold1[16]);

    assign ram_we    = acc && in_hdr;
    assign ram_waddr = bank_addr(wbank_reg, pos_reg);
    assign ram_wdata = in_byte;

    assign cmd_push    = acc && (!in_hdr || hdr_end);
    assign cmd.is_hdr  = in_hdr;
    assign cmd.bank    = wbank_reg;
    assign cmd.len     = pos_reg + POS_W'(1);
    assign cmd.last    = in_last;
    assign cmd.verdict = in_hdr ? (full_hdr && fwd) : verdict_reg;
    assign cmd.data    = in_byte;
    assign cmd.mac     = sel_mac;
    assign cmd.ip      = sel_ip;
    assign cmd.cksum   = ~fold2[15:0];

    always_comb
    begin
        pos_next     = pos_reg;
        wbank_next   = wbank_reg;
        busy_next    = busy_reg;
        next_be_next = next_be_reg;
        verdict_next = verdict_reg;
        sum_next     = sum_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (acc && in_hdr)
        begin
            if (pos_reg == '0)
            begin
                sum_next = '0;
            end
            else if (ck_word)
            begin
                sum_next = sum_reg + SUM_W'({hi_reg, in_byte});
            end
            else if (pos_reg == POS_DIP_0)
            begin
                sum_next = sum_reg + SUM_W'(sel_ip[31:16]);
            end
            else if (pos_reg == POS_DIP_1)
            begin
                sum_next = sum_reg + SUM_W'(sel_ip[15:0]);
            end
            if (hdr_end)
            begin
                wbank_next           = ~wbank_reg;
                busy_next[wbank_reg] = 1'b1;
                pos_next             = (full_hdr && !in_last) ? POS_BODY : '0;
                verdict_next         = full_hdr && fwd;
                if (full_hdr && fwd)
                begin
                    next_be_next = ~next_be_reg;
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        else if (acc && in_last)
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            wbank_reg   <= 1'b0;
            busy_reg    <= '0;
            next_be_reg <= 1'b0;
            verdict_reg <= 1'b0;
            b0_ip_reg   <= '0;
            b0_mac_reg  <= '0;
            b1_ip_reg   <= '0;
            b1_mac_reg  <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            wbank_reg   <= wbank_next;
            busy_reg    <= busy_next;
            next_be_reg <= next_be_next;
            verdict_reg <= verdict_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_BACKEND0_IP:  b0_ip_reg  <= cfg_data[31:0];
                    CFG_BACKEND0_MAC: b0_mac_reg <= cfg_data;
                    CFG_BACKEND1_IP:  b1_ip_reg  <= cfg_data[31:0];
                    CFG_BACKEND1_MAC: b1_mac_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Header field capture and checksum accumulator
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (acc && in_hdr)
        begin
            hi_reg <= in_byte;
            if (pos_reg == POS_ETYPE_HI)
            begin
                etype_hi_reg <= in_byte;
            end
            if (pos_reg == POS_ETYPE_LO)
            begin
                etype_lo_reg <= in_byte;
            end
            if (pos_reg == POS_PROTO)
            begin
                proto_reg <= in_byte;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_BODY)
        else $error("byte position beyond header length");
    a_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_end |-> !busy_reg[wbank_reg])
        else $error("header written into a bank still being read");
    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid |-> busy_reg[rel.bank])
        else $error("release of a bank that was not busy");
`endif

endmodule

FILE: hw/rtl/lbhr_back.sv
// Back end: executes commands, rewrites header bytes and feeds the result queue.
module lbhr_back
    import lbhr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    output logic              ram_re,
    output logic [RAM_AW-1:0] ram_raddr,
    input  logic [7:0]        ram_rdata,
    input  logic [OQ_CW-1:0]  ocount,
    output logic              opush,
    output obeat_t            obeat,
    output release_t          rel
);

    logic [POS_W-1:0] idx_reg, idx_next;
    logic             b_valid_reg;
    logic             b_src_ram_reg;
    obeat_t           b_beat_reg;

    logic             credit, issue, hdr_last, src_ram;
    logic [POS_W-1:0] rd_pos;
    logic [7:0]       lit;
    obeat_t           beat;

    // Count the beat in flight so the result queue never overflows
    assign credit   = (({1'b0, ocount} + (OQ_CW + 1)'(b_valid_reg)) <
                       (OQ_CW + 1)'(OQ_DEPTH));
    assign issue    = !cmd_empty && credit;
    assign hdr_last = (idx_reg == cmd.len - POS_W'(1));
    assign cmd_pop  = issue && (!cmd.is_hdr || hdr_last);

    assign rel.valid = issue && cmd.is_hdr && hdr_last;
    assign rel.bank  = cmd.bank;

    always_comb
    begin
        rd_pos  = idx_reg;
        lit     = cmd.data;
        src_ram = cmd.is_hdr;
        if (cmd.is_hdr && cmd.verdict)
        begin
            case (idx_reg)
                6'd0:       begin lit = cmd.mac[47:40]; src_ram = 1'b0; end
                6'd1:       begin lit = cmd.mac[39:32]; src_ram = 1'b0; end
                6'd2:       begin lit = cmd.mac[31:24]; src_ram = 1'b0; end
                6'd3:       begin lit = cmd.mac[23:16]; src_ram = 1'b0; end
                6'd4:       begin lit = cmd.mac[15:8];  src_ram = 1'b0; end
                6'd5:       begin lit = cmd.mac[7:0];   src_ram = 1'b0; end
                // old destination MAC becomes the source MAC
                6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11:
                    rd_pos = idx_reg - POS_W'(6);
                POS_CK_HI:  begin lit = cmd.cksum[15:8]; src_ram = 1'b0; end
                POS_CK_LO:  begin lit = cmd.cksum[7:0];  src_ram = 1'b0; end
                POS_DIP_0:  begin lit = cmd.ip[31:24];   src_ram = 1'b0; end
                POS_DIP_1:  begin lit = cmd.ip[23:16];   src_ram = 1'b0; end
                POS_DIP_2:  begin lit = cmd.ip[15:8];    src_ram = 1'b0; end
                POS_DIP_3:  begin lit = cmd.ip[7:0];     src_ram = 1'b0; end
                default: ;
            endcase
        end
        beat.data    = lit;
        beat.last    = cmd.is_hdr ? (cmd.last && hdr_last) : cmd.last;
        beat.verdict = cmd.verdict;
    end

    assign ram_re    = issue && src_ram;
    assign ram_raddr = bank_addr(cmd.bank, rd_pos);

    always_comb
    begin
        idx_next = idx_reg;
        if (issue && cmd.is_hdr)
        begin
            idx_next = hdr_last ? '0 : idx_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            b_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_src_ram_reg <= src_ram;
            b_beat_reg    <= beat;
        end
    end

    assign opush         = b_valid_reg;
    assign obeat.data    = b_src_ram_reg ? ram_rdata : b_beat_reg.data;
    assign obeat.last    = b_beat_reg.last;
    assign obeat.verdict = b_beat_reg.verdict;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (ocount < OQ_CW'(OQ_DEPTH)))
        else $error("result queue full when a beat arrives");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd_empty && cmd.is_hdr) |-> (idx_reg < cmd.len))
        else $error("header index past header length");
    a_hdr_held: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (!cmd_empty && cmd.is_hdr))
        else $error("header command left the queue mid-burst");
`endif

endmodule

FILE: hw/rtl/l2_load_balancer_header_rewrite_unit.sv
// Top level of the L2 load-balancer header rewrite unit.
// Path: with idle queues a body byte, or the first beat of a header once its final byte is
//   accepted, passes the command queue, the back end's beat register and the result queue.
// Throughput: one beat per cycle on each side at best; while a 34-beat header drains, the front
//   takes CMDQ_DEPTH - 1 body bytes, then stalls until the header command leaves the queue.
// Reset: async, active low; clears queues, position, toggle, verdict, backends; not header RAM.
module l2_load_balancer_header_rewrite_unit
    import lbhr_pkg::*;
#(
    parameter int CMDQ_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // frame bytes in
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    // result beats out
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        verdict,
    // backend configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    // Front to back command path
    cmd_t              cmd_in, cmd_out;
    logic              cmd_push, cmd_pop, cmd_empty, cmdq_full;
    release_t          rel;

    // Header RAM: two banks so the next header fills while the last one drains
    logic              ram_we, ram_re;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    // Result queue
    logic              opush;
    obeat_t            obeat, ohead;
    logic [OQ_CW-1:0]  ocount;

    lbhr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmdq_full (cmdq_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .rel       (rel)
    );

    lbhr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Hold commands so the front keeps taking bytes while a header drains
    lbhr_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty),
        .full  (cmdq_full),
        .count ()
    );

    lbhr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ocount    (ocount),
        .opush     (opush),
        .obeat     (obeat),
        .rel       (rel)
    );

    // Result queue parts the back end from the consumer; the back end
    // reserves a slot before it issues each beat
    lbhr_fifo #(
        .WIDTH ($bits(obeat_t)),
        .DEPTH (OQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (opush),
        .wdata (obeat),
        .pop   (pop),
        .rdata (ohead),
        .empty (empty),
        .full  (),
        .count (ocount)
    );

    assign out_byte = ohead.data;
    assign out_last = ohead.last;
    assign verdict  = ohead.verdict;

endmodule
